// File: design/tce_pkg.sv
// shared types and constants of the thrift compact encoder
package tce_pkg;

    localparam int MAX_BYTES  = 11;
    localparam int VINT_BYTES = 10;
    localparam int CNT_W      = 4;

    localparam logic [3:0] TYPE_STRUCT = 4'd12;
    localparam logic [7:0] CONT_BIT    = 8'h80;
    localparam logic [7:0] LIST_LONG   = 8'hF0;
    localparam logic [7:0] STOP_BYTE   = 8'h00;
    localparam logic [63:0] LIST_SHORT_LIMIT = 64'd15;

    typedef enum logic [2:0] {
        KIND_FIELD  = 3'd0,
        KIND_ZIGZAG = 3'd1,
        KIND_UVAR   = 3'd2,
        KIND_LIST   = 3'd3,
        KIND_ENTER  = 3'd4,
        KIND_LEAVE  = 3'd5,
        KIND_STOP   = 3'd6,
        KIND_RAW    = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] field_id;
        logic [3:0]         type_code;
        logic [63:0]        value;
    } tok_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       nest_error;
    } enc_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      nest_error;
    } burst_t;

endpackage

// File: design/tce_encoder.sv
// token input register, nesting state and one-pass byte encoding of a token
module tce_encoder #(
    parameter int NEST_DEPTH = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid,
    output logic            tok_ready,
    input  tce_pkg::tok_t   tok,
    output logic            burst_valid,
    input  logic            burst_ready,
    output tce_pkg::burst_t burst
);

    localparam int LVL_W = $clog2(NEST_DEPTH + 1);
    localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    logic                in_valid_reg;
    tce_pkg::tok_t       in_reg;
    logic signed [15:0]  last_id_reg;
    logic signed [15:0]  last_id_next;
    logic [LVL_W-1:0]    level_reg;
    logic [LVL_W-1:0]    level_next;
    logic signed [15:0]  saved_ids_reg [NEST_DEPTH];

    logic                fire;
    logic                push;
    logic [LVL_W-1:0]    level_dec;
    logic [IDX_W-1:0]    push_idx;
    logic [IDX_W-1:0]    pop_idx;
    logic                full;
    logic                empty;
    logic [16:0]         delta;
    logic                short_hdr;
    logic [16:0]         zz_id;
    logic [63:0]         zz_val;
    logic [3:0]          hdr_type;
    logic                has_prefix;
    logic                has_varint;
    logic [7:0]          prefix;
    logic [63:0]         vval;
    logic [69:0]         vext;
    logic [3:0]          vlen;
    logic [tce_pkg::VINT_BYTES-1:0][7:0] vbytes;
    logic                err;

    assign fire        = in_valid_reg && burst_ready;
    assign tok_ready   = !in_valid_reg || burst_ready;
    assign burst_valid = in_valid_reg;

    assign full      = (level_reg == LVL_W'(NEST_DEPTH));
    assign empty     = (level_reg == '0);
    assign level_dec = level_reg - LVL_W'(1);
    assign push_idx  = level_reg[IDX_W-1:0];
    assign pop_idx   = level_dec[IDX_W-1:0];

    assign delta     = {in_reg.field_id[15], in_reg.field_id}
                     - {last_id_reg[15], last_id_reg};
    assign short_hdr = (delta[16:4] == '0) && (delta[3:0] != 4'd0);
    assign zz_id     = {in_reg.field_id, 1'b0} ^ {17{in_reg.field_id[15]}};
    assign zz_val    = {in_reg.value[62:0], 1'b0} ^ {64{in_reg.value[63]}};
    assign hdr_type  = (in_reg.kind == tce_pkg::KIND_ENTER) ? tce_pkg::TYPE_STRUCT
                                                             : in_reg.type_code;

    always_comb
    begin
        has_prefix   = 1'b1;
        has_varint   = 1'b0;
        prefix       = tce_pkg::STOP_BYTE;
        vval         = '0;
        err          = 1'b0;
        push         = 1'b0;
        last_id_next = last_id_reg;
        level_next   = level_reg;
        unique case (in_reg.kind)
            tce_pkg::KIND_FIELD, tce_pkg::KIND_ENTER:
            begin
                if (short_hdr)
                begin
                    prefix = {delta[3:0], hdr_type};
                end
                else
                begin
                    prefix     = {4'h0, hdr_type};
                    has_varint = 1'b1;
                    vval       = {47'd0, zz_id};
                end
                last_id_next = in_reg.field_id;
                if (in_reg.kind == tce_pkg::KIND_ENTER)
                begin
                    if (!full)
                    begin
                        push         = 1'b1;
                        level_next   = level_reg + LVL_W'(1);
                        last_id_next = '0;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
            end
            tce_pkg::KIND_ZIGZAG:
            begin
                has_prefix = 1'b0;
                has_varint = 1'b1;
                vval       = zz_val;
            end
            tce_pkg::KIND_UVAR:
            begin
                has_prefix = 1'b0;
                has_varint = 1'b1;
                vval       = in_reg.value;
            end
            tce_pkg::KIND_LIST:
            begin
                if (in_reg.value < tce_pkg::LIST_SHORT_LIMIT)
                begin
                    prefix = {in_reg.value[3:0], in_reg.type_code};
                end
                else
                begin
                    prefix     = tce_pkg::LIST_LONG | {4'h0, in_reg.type_code};
                    has_varint = 1'b1;
                    vval       = in_reg.value;
                end
            end
            tce_pkg::KIND_LEAVE:
            begin
                if (!empty)
                begin
                    level_next   = level_dec;
                    last_id_next = saved_ids_reg[pop_idx];
                end
                else
                begin
                    err = 1'b1;
                end
            end
            tce_pkg::KIND_STOP:
            begin
                prefix = tce_pkg::STOP_BYTE;
            end
            tce_pkg::KIND_RAW:
            begin
                prefix = in_reg.value[7:0];
            end
            default:
            begin
                prefix = tce_pkg::STOP_BYTE;
            end
        endcase
    end

    // varint length and 7-bit groups
    assign vext = {6'd0, vval};

    always_comb
    begin
        vlen = 4'd1;
        for (int g = 1; g < tce_pkg::VINT_BYTES; g++)
        begin
            if ((vval >> (7 * g)) != 64'd0)
            begin
                vlen = 4'(g + 1);
            end
        end
        for (int k = 0; k < tce_pkg::VINT_BYTES; k++)
        begin
            vbytes[k] = {(4'(k) + 4'd1 < vlen), vext[7*k +: 7]};
        end
    end

    always_comb
    begin
        burst.bytes = '0;
        if (has_prefix)
        begin
            burst.bytes[0] = prefix;
            for (int k = 1; k < tce_pkg::MAX_BYTES; k++)
            begin
                burst.bytes[k] = vbytes[k-1];
            end
        end
        else
        begin
            for (int k = 0; k < tce_pkg::VINT_BYTES; k++)
            begin
                burst.bytes[k] = vbytes[k];
            end
        end
        burst.count = tce_pkg::CNT_W'({3'd0, has_prefix})
                    + (has_varint ? vlen : 4'd0);
        burst.nest_error = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            last_id_reg  <= '0;
            level_reg    <= '0;
        end
        else
        begin
            if (tok_ready)
            begin
                in_valid_reg <= tok_valid;
            end
            if (fire)
            begin
                last_id_reg <= last_id_next;
                level_reg   <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_ready && tok_valid)
        begin
            in_reg <= tok;
        end
        if (fire && push)
        begin
            saved_ids_reg[push_idx] <= in_reg.field_id;
        end
    end

endmodule

// File: design/tce_serializer.sv
// byte buffer that shifts one encoded token out a byte at a time
module tce_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            burst_valid,
    output logic            burst_ready,
    input  tce_pkg::burst_t burst,
    output logic            enc_valid,
    input  logic            enc_ready,
    output tce_pkg::enc_t   enc
);

    logic                                valid_reg;
    logic [tce_pkg::CNT_W-1:0]           rem_reg;
    logic [tce_pkg::MAX_BYTES-1:0][7:0]  bytes_reg;
    logic                                err_reg;
    logic                                last;
    logic                                take;

    assign last        = (rem_reg == tce_pkg::CNT_W'(1));
    assign take        = valid_reg && enc_ready;
    assign burst_ready = !valid_reg || (enc_ready && last);

    assign enc_valid      = valid_reg;
    assign enc.out_byte   = bytes_reg[0];
    assign enc.last_byte  = last;
    assign enc.nest_error = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else if (burst_ready && burst_valid)
        begin
            valid_reg <= 1'b1;
            rem_reg   <= burst.count;
        end
        else if (take)
        begin
            valid_reg <= !last;
            rem_reg   <= rem_reg - tce_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_ready && burst_valid)
        begin
            bytes_reg <= burst.bytes;
            err_reg   <= burst.nest_error;
        end
        else if (take)
        begin
            bytes_reg <= {8'h00, bytes_reg[tce_pkg::MAX_BYTES-1:1]};
        end
    end

endmodule

// File: design/thrift_compact_encoder.sv
// Thrift compact-protocol encoder: one token in, one to eleven bytes out, one
// byte per cycle while enc_ready is high; the byte-wide buffer sets the rate.
// A token is registered, encoded in one pass and loaded into a byte shift
// buffer as the last byte of the one before is taken, so one-byte tokens
// flow at one per cycle while enc_ready is high and a longer token holds the
// input until its last byte is taken. A token passes the input register and
// the byte buffer before its first byte appears. NEST_DEPTH sets the saved
// field id stack depth; overflow and underflow flag nest_error on every byte.
module thrift_compact_encoder #(
    parameter int NEST_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_valid,
    output logic          tok_ready,
    input  tce_pkg::tok_t tok,
    output logic          enc_valid,
    input  logic          enc_ready,
    output tce_pkg::enc_t enc
);

    logic            burst_valid;
    logic            burst_ready;
    tce_pkg::burst_t burst;

    tce_encoder #(
        .NEST_DEPTH (NEST_DEPTH)
    ) u_encoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (tok_valid),
        .tok_ready   (tok_ready),
        .tok         (tok),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    tce_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst),
        .enc_valid   (enc_valid),
        .enc_ready   (enc_ready),
        .enc         (enc)
    );

endmodule

// File: design/tce_checker.sv
// port-level assertions for the thrift compact encoder and their bind
module tce_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          tok_valid,
    input logic          tok_ready,
    input tce_pkg::tok_t tok,
    input logic          enc_valid,
    input logic          enc_ready,
    input tce_pkg::enc_t enc
);

    // stalled output item holds
    a_enc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && !enc_ready |=> enc_valid && $stable(enc))
        else $error("output item changed while stalled");

    // bytes of one token follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && enc_ready && !enc.last_byte |=> enc_valid)
        else $error("gap inside a token's bytes");

    // error flag is the same on every byte of a token
    a_err_steady: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && enc_ready && !enc.last_byte
        |=> enc.nest_error == $past(enc.nest_error))
        else $error("nest_error changed inside a token");

endmodule

bind thrift_compact_encoder tce_checker u_tce_checker (.*);
